@@ design/ccfr_pkg.sv @@
// ccfr_pkg: shared types, codes and the crc-16-ccitt step for the frame receiver
// no dependencies
`default_nettype none
package ccfr_pkg;

  localparam int RawLimitDef = 256;
  localparam logic [7:0] MaxPayloadRst = 8'd250;
  localparam logic [15:0] CrcInitRst = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [8:0] DecodedCap = 9'd511;

  localparam logic [7:0] ByteDelim = 8'h00;
  localparam logic [7:0] ByteFullCode = 8'hFF;

  // configuration register indexes
  localparam logic RegMaxPayload = 1'b0;
  localparam logic RegCrcInit = 1'b1;

  localparam logic KindByte = 1'b0;
  localparam logic KindVerdict = 1'b1;

  localparam logic [1:0] VerdictOk = 2'd0;
  localparam logic [1:0] VerdictCrc = 2'd1;
  localparam logic [1:0] VerdictDrop = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_DATA,
    OP_CLOSE
  } op_code_t;

  typedef struct packed {
    op_code_t code;
    logic [7:0] data;
    logic group_bad;
  } op_t;

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/ccfr_fifo.sv @@
// ccfr_fifo: two-entry op queue between the decoder front and the parser back
// depends on ccfr_pkg
`default_nettype none
module ccfr_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  ccfr_pkg::op_t      push_op,
  output logic               full,
  output logic               valid,
  input  wire logic          pop,
  output ccfr_pkg::op_t      head
);
  import ccfr_pkg::*;

  op_t mem_r [2];
  logic wr_ptr_r, wr_ptr_nxt;
  logic rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_op;
  end

endmodule
`default_nettype wire

@@ design/ccfr_front.sv @@
// ccfr_front: accepts wire bytes, tracks cobs groups and turns each byte into at most one op
// depends on ccfr_pkg
`default_nettype none
module ccfr_front #(
  parameter int RAW_LIMIT = ccfr_pkg::RawLimitDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_raw_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output ccfr_pkg::op_t      q_op
);
  import ccfr_pkg::*;

  localparam int RcW = $clog2(RAW_LIMIT + 1);

  logic [RcW-1:0] raw_count_r, raw_count_nxt;
  logic [7:0] grp_rem_r, grp_rem_nxt;
  logic grp_full_r, grp_full_nxt;
  logic accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    raw_count_nxt = raw_count_r;
    grp_rem_nxt = grp_rem_r;
    grp_full_nxt = grp_full_r;
    q_push = 1'b0;
    q_op.code = OP_DATA;
    q_op.data = in_raw_byte;
    q_op.group_bad = (grp_rem_r != 8'd0);
    if (accept) begin
      priority if (in_raw_byte == ByteDelim) begin
        if (raw_count_r != '0) begin
          q_push = 1'b1;
          q_op.code = OP_CLOSE;
        end
        raw_count_nxt = '0;
        grp_rem_nxt = 8'd0;
        grp_full_nxt = 1'b0;
      end else if (raw_count_r >= RcW'(RAW_LIMIT)) begin
        // frame too long: drop it silently
        raw_count_nxt = '0;
        grp_rem_nxt = 8'd0;
        grp_full_nxt = 1'b0;
      end else begin
        priority if (raw_count_r == '0) begin
          q_push = 1'b1;
          q_op.code = OP_START;
        end else if (grp_rem_r == 8'd0) begin
          // implicit zero between groups unless the last group was full
          q_push = !grp_full_r;
          q_op.data = 8'd0;
        end else begin
          q_push = 1'b1;
        end
        if (grp_rem_r == 8'd0) begin
          grp_rem_nxt = in_raw_byte - 8'd1;
          grp_full_nxt = (in_raw_byte == ByteFullCode);
        end else begin
          grp_rem_nxt = grp_rem_r - 8'd1;
        end
        raw_count_nxt = raw_count_r + RcW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_count_r <= '0;
      grp_rem_r <= 8'd0;
      grp_full_r <= 1'b0;
    end else begin
      raw_count_r <= raw_count_nxt;
      grp_rem_r <= grp_rem_nxt;
      grp_full_r <= grp_full_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/ccfr_back.sv @@
// ccfr_back: parses decoded bytes, runs the crc and drives the registered result beat
// depends on ccfr_pkg
`default_nettype none
module ccfr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  ccfr_pkg::op_t      q_head,
  output logic               q_pop,
  input  wire logic [7:0]    max_payload,
  input  wire logic [15:0]   crc_init,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_kind,
  output logic [7:0]         out_data_byte,
  output logic [1:0]         out_verdict,
  output logic [7:0]         out_frame_type,
  output logic [7:0]         out_frame_sequence,
  output logic [15:0]        out_payload_length
);
  import ccfr_pkg::*;

  logic [8:0] dcount_r, dcount_nxt;
  logic [7:0] htype_r, htype_nxt;
  logic [7:0] hseq_r, hseq_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0] hold0_r, hold0_nxt;
  logic [7:0] hold1_r, hold1_nxt;
  logic err_r, err_nxt;

  logic out_valid_r, out_valid_nxt;
  logic kind_r, kind_nxt;
  logic [7:0] data_r, data_nxt;
  logic [1:0] verdict_r, verdict_nxt;
  logic [7:0] otype_r, otype_nxt;
  logic [7:0] oseq_r, oseq_nxt;
  logic [15:0] olen_r, olen_nxt;

  logic emit;
  logic [8:0] pay_idx;
  logic bad;

  assign q_pop = q_valid && (!out_valid_r || out_ready);
  assign pay_idx = dcount_r - 9'd4;
  assign bad = err_r || q_head.group_bad || (dcount_r < 9'd6) ||
               (hlen_r > {8'd0, max_payload}) ||
               ({8'd0, dcount_r} != (17'd6 + {1'b0, hlen_r}));

  always_comb begin
    dcount_nxt = dcount_r;
    htype_nxt = htype_r;
    hseq_nxt = hseq_r;
    hlen_nxt = hlen_r;
    crc_nxt = crc_r;
    hold0_nxt = hold0_r;
    hold1_nxt = hold1_r;
    err_nxt = err_r;
    emit = 1'b0;
    kind_nxt = KindByte;
    data_nxt = q_head.data;
    verdict_nxt = VerdictOk;
    otype_nxt = 8'd0;
    oseq_nxt = 8'd0;
    olen_nxt = 16'd0;
    if (q_pop) begin
      unique case (q_head.code)
        OP_START: begin
          dcount_nxt = 9'd0;
          htype_nxt = 8'd0;
          hseq_nxt = 8'd0;
          hlen_nxt = 16'd0;
          crc_nxt = crc_init;
          hold0_nxt = 8'd0;
          hold1_nxt = 8'd0;
          err_nxt = 1'b0;
        end
        OP_DATA: begin
          if (!err_r) begin
            if (dcount_r >= DecodedCap) begin
              err_nxt = 1'b1;
            end else begin
              // oldest held byte is proven not to be crc, feed it
              if (dcount_r >= 9'd2) crc_nxt = crc16_feed(crc_r, hold0_r);
              hold0_nxt = hold1_r;
              hold1_nxt = q_head.data;
              dcount_nxt = dcount_r + 9'd1;
              priority if (dcount_r == 9'd0) begin
                htype_nxt = q_head.data;
              end else if (dcount_r == 9'd1) begin
                hseq_nxt = q_head.data;
              end else if (dcount_r == 9'd2) begin
                hlen_nxt = {hlen_r[15:8], q_head.data};
              end else if (dcount_r == 9'd3) begin
                hlen_nxt = {q_head.data, hlen_r[7:0]};
              end else begin
                emit = ({7'd0, pay_idx} < hlen_r);
              end
            end
          end
        end
        OP_CLOSE: begin
          emit = 1'b1;
          kind_nxt = KindVerdict;
          data_nxt = 8'd0;
          if (bad) verdict_nxt = VerdictDrop;
          else if ({hold1_r, hold0_r} == crc_r) verdict_nxt = VerdictOk;
          else verdict_nxt = VerdictCrc;
          otype_nxt = htype_r;
          oseq_nxt = hseq_r;
          olen_nxt = hlen_r;
        end
        default: ;
      endcase
    end
    if (emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dcount_r <= 9'd0;
      err_r <= 1'b0;
      htype_r <= 8'd0;
      hseq_r <= 8'd0;
      hlen_r <= 16'd0;
      crc_r <= CrcInitRst;
      hold0_r <= 8'd0;
      hold1_r <= 8'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      dcount_r <= dcount_nxt;
      err_r <= err_nxt;
      htype_r <= htype_nxt;
      hseq_r <= hseq_nxt;
      hlen_r <= hlen_nxt;
      crc_r <= crc_nxt;
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      verdict_r <= verdict_nxt;
      otype_r <= otype_nxt;
      oseq_r <= oseq_nxt;
      olen_r <= olen_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = kind_r;
  assign out_data_byte = data_r;
  assign out_verdict = verdict_r;
  assign out_frame_type = otype_r;
  assign out_frame_sequence = oseq_r;
  assign out_payload_length = olen_r;

endmodule
`default_nettype wire

@@ design/cobs_crc_frame_receiver_unit.sv @@
// cobs_crc_frame_receiver_unit: one wire byte per cycle in while in_ready is high, payload bytes and verdicts out
// a byte's result beat is registered first into the op queue and then into the output
// register; a full queue or a held output beat can stall it in between
// throughput: one byte per cycle while in_ready is high; the crc step in the back part is combinational
// reset (synchronous, rst_n low): queue and output empty, max_payload 250, crc_init 0xffff
// no clearing pass; the block accepts bytes right after reset
// depends on ccfr_pkg, ccfr_front, ccfr_fifo, ccfr_back
`default_nettype none
module cobs_crc_frame_receiver_unit #(
  parameter int RAW_LIMIT = ccfr_pkg::RawLimitDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // wire byte channel
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_raw_byte,
  // result channel
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_kind,
  output logic [7:0]         out_data_byte,
  output logic [1:0]         out_verdict,
  output logic [7:0]         out_frame_type,
  output logic [7:0]         out_frame_sequence,
  output logic [15:0]        out_payload_length,
  // register port
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ccfr_pkg::*;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  logic [7:0] max_payload_r;
  logic [15:0] crc_init_r;
  logic cfg_wr;

  // queue between the decoder front and the parser back
  op_t q_op, q_head;
  logic q_push, q_full, q_valid, q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MaxPayloadRst;
      crc_init_r <= CrcInitRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegMaxPayload: max_payload_r <= pwdata[7:0];
        RegCrcInit:    crc_init_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegMaxPayload: prdata = {24'd0, max_payload_r};
      RegCrcInit:    prdata = {16'd0, crc_init_r};
      default:       prdata = 32'd0;
    endcase
  end

  // front: cobs group tracking, one op per byte at most
  ccfr_front #(
    .RAW_LIMIT(RAW_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_raw_byte(in_raw_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (q_op)
  );

  ccfr_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .push_op(q_op),
    .full   (q_full),
    .valid  (q_valid),
    .pop    (q_pop),
    .head   (q_head)
  );

  // back: header parse, crc, length checks and the output register
  ccfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .max_payload       (max_payload_r),
    .crc_init          (crc_init_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_verdict       (out_verdict),
    .out_frame_type    (out_frame_type),
    .out_frame_sequence(out_frame_sequence),
    .out_payload_length(out_payload_length)
  );

endmodule
`default_nettype wire
